// File: sv/ufml_pkg.sv
// shared constants and result type for the union-find block with member lists
// no dependencies
`default_nettype none

package ufml_pkg;

    localparam int unsigned KEY_W             = 6;
    localparam int unsigned ACT_W             = 2;
    localparam int unsigned DEF_ELEMENT_COUNT = 64;
    localparam int unsigned MAX_RESULTS       = 64;
    localparam int unsigned CNT_W             = $clog2(MAX_RESULTS);

    localparam logic [ACT_W-1:0] ACT_UNITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LIST  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] root;
        logic [KEY_W-1:0] member;
        logic             merged;
        logic             last;
    } ufml_res_t;

endpackage

`default_nettype wire

// File: sv/ufml_in_if.sv
// request channel: action and two keys with valid/ready
// depends on ufml_pkg
`default_nettype none

interface ufml_in_if import ufml_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;

    modport source (output valid, action, first_key, second_key, input ready);
    modport sink (input valid, action, first_key, second_key, output ready);
endinterface

`default_nettype wire

// File: sv/ufml_out_if.sv
// result channel: root, member, merged and last with valid/ready
// depends on ufml_pkg
`default_nettype none

interface ufml_out_if import ufml_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] root;
    logic [KEY_W-1:0] member;
    logic             merged;
    logic             last;

    modport source (output valid, root, member, merged, last, input ready);
    modport sink (input valid, root, member, merged, last, output ready);
endinterface

`default_nettype wire

// File: sv/ufml_table.sv
// the four per-element tables: parent, set size, list tail, next member
// one read address shared by all tables with registered read data, one write port per table
`default_nettype none

module ufml_table import ufml_pkg::*; #(
    parameter int unsigned ELEMENT_COUNT = DEF_ELEMENT_COUNT
) (
    input  wire logic clk,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   rd_addr,
    input  wire logic                               par_we,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   par_addr,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   par_data,
    input  wire logic                               siz_we,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   siz_addr,
    input  wire logic [$clog2(ELEMENT_COUNT+1)-1:0] siz_data,
    input  wire logic                               tail_we,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   tail_addr,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   tail_data,
    input  wire logic                               nxt_we,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   nxt_addr,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   nxt_data,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   par_q,
    output logic      [$clog2(ELEMENT_COUNT+1)-1:0] siz_q,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   tail_q,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   nxt_q
);

    localparam int unsigned IDX_W  = $clog2(ELEMENT_COUNT);
    localparam int unsigned SIZE_W = $clog2(ELEMENT_COUNT + 1);

    logic [IDX_W-1:0]  par_mem  [ELEMENT_COUNT];
    logic [SIZE_W-1:0] siz_mem  [ELEMENT_COUNT];
    logic [IDX_W-1:0]  tail_mem [ELEMENT_COUNT];
    logic [IDX_W-1:0]  nxt_mem  [ELEMENT_COUNT];

    logic [IDX_W-1:0]  par_q_reg;
    logic [SIZE_W-1:0] siz_q_reg;
    logic [IDX_W-1:0]  tail_q_reg;
    logic [IDX_W-1:0]  nxt_q_reg;

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_addr] <= par_data;
        end
        par_q_reg <= par_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (siz_we)
        begin
            siz_mem[siz_addr] <= siz_data;
        end
        siz_q_reg <= siz_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[tail_addr] <= tail_data;
        end
        tail_q_reg <= tail_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_addr] <= nxt_data;
        end
        nxt_q_reg <= nxt_mem[rd_addr];
    end

    assign par_q  = par_q_reg;
    assign siz_q  = siz_q_reg;
    assign tail_q = tail_q_reg;
    assign nxt_q  = nxt_q_reg;

endmodule

`default_nettype wire

// File: sv/ufml_ctrl.sv
// sequencer: clearing sweep, shared root walker, union merge and list walk
// depends on ufml_pkg; drives ufml_table ports and a result push
`default_nettype none

module ufml_ctrl import ufml_pkg::*; #(
    parameter int unsigned ELEMENT_COUNT = DEF_ELEMENT_COUNT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic                               req_valid,
    input  wire logic [ACT_W-1:0]                   req_action,
    input  wire logic [KEY_W-1:0]                   req_first,
    input  wire logic [KEY_W-1:0]                   req_second,
    output logic                                    req_ready,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   rd_addr,
    output logic                                    par_we,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   par_addr,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   par_data,
    output logic                                    siz_we,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   siz_addr,
    output logic      [$clog2(ELEMENT_COUNT+1)-1:0] siz_data,
    output logic                                    tail_we,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   tail_addr,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   tail_data,
    output logic                                    nxt_we,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   nxt_addr,
    output logic      [$clog2(ELEMENT_COUNT)-1:0]   nxt_data,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   par_q,
    input  wire logic [$clog2(ELEMENT_COUNT+1)-1:0] siz_q,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   tail_q,
    input  wire logic [$clog2(ELEMENT_COUNT)-1:0]   nxt_q,
    input  wire logic                               slot_free,
    output logic                                    res_push,
    output ufml_res_t                               res
);

    localparam int unsigned IDX_W  = $clog2(ELEMENT_COUNT);
    localparam int unsigned SIZE_W = $clog2(ELEMENT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_UBIG   = 7'b0001000,
        S_USMALL = 7'b0010000,
        S_LIST   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic              phase_reg, phase_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [IDX_W-1:0]  big_reg, big_next;
    logic [IDX_W-1:0]  small_reg, small_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [SIZE_W-1:0] sizb_reg, sizb_next;
    logic [IDX_W-1:0]  tailb_reg, tailb_next;
    ufml_res_t         res_reg, res_next;

    logic              a_ok, b_ok, p_ok, n_ok;
    logic              found, swap, list_end;
    logic [IDX_W-1:0]  found_root;
    logic [IDX_W-1:0]  new_big, new_small, tail_big, tail_small;
    logic [SIZE_W-1:0] size_sum;

    always_comb
    begin
        a_ok     = 32'(req_first) < ELEMENT_COUNT;
        b_ok     = 32'(req_second) < ELEMENT_COUNT;
        p_ok     = 32'(par_q) < ELEMENT_COUNT;
        n_ok     = 32'(nxt_q) < ELEMENT_COUNT;
        // shared walker step
        found      = 1'b0;
        found_root = cur_reg;
        if (par_q == cur_reg || !p_ok)
        begin
            found = 1'b1;
        end
        else if (steps_reg == LAST_IDX)
        begin
            found      = 1'b1;
            found_root = par_q;
        end
        // merge datapath
        swap       = sizb_reg < siz_q;
        new_big    = swap ? small_reg : big_reg;
        new_small  = swap ? big_reg : small_reg;
        tail_big   = swap ? tail_q : tailb_reg;
        tail_small = swap ? tailb_reg : tail_q;
        size_sum   = sizb_reg + siz_q;
        list_end   = (nxt_q == cur_reg) || !n_ok || (cnt_reg == LAST_CNT);
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        cnt_next   = cnt_reg;
        b_next     = b_reg;
        big_next   = big_reg;
        small_next = small_reg;
        root_next  = root_reg;
        sizb_next  = sizb_reg;
        tailb_next = tailb_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_push   = 1'b0;
        res        = res_reg;
        rd_addr    = cur_reg;
        par_we     = 1'b0;
        par_addr   = cur_reg;
        par_data   = cur_reg;
        siz_we     = 1'b0;
        siz_addr   = cur_reg;
        siz_data   = SIZE_W'(1);
        tail_we    = 1'b0;
        tail_addr  = cur_reg;
        tail_data  = cur_reg;
        nxt_we     = 1'b0;
        nxt_addr   = cur_reg;
        nxt_data   = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                par_we  = 1'b1;
                siz_we  = 1'b1;
                tail_we = 1'b1;
                nxt_we  = 1'b1;
                if (cur_reg == LAST_IDX)
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act_next   = req_action;
                    b_next     = IDX_W'(req_second);
                    cur_next   = IDX_W'(req_first);
                    rd_addr    = IDX_W'(req_first);
                    steps_next = '0;
                    phase_next = 1'b0;
                    case (req_action)
                        ACT_UNITE:
                        begin
                            res_next = '{root: req_first, member: '0, merged: 1'b0,
                                         last: 1'b1};
                            state_next = (a_ok && b_ok) ? S_WALK : S_EMIT;
                        end
                        ACT_FIND:
                        begin
                            res_next = '{root: req_first, member: '0, merged: 1'b0,
                                         last: 1'b1};
                            state_next = a_ok ? S_WALK : S_EMIT;
                        end
                        ACT_LIST:
                        begin
                            res_next = '{root: req_first, member: req_first,
                                         merged: 1'b0, last: 1'b1};
                            state_next = a_ok ? S_WALK : S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (!found)
                begin
                    cur_next   = par_q;
                    rd_addr    = par_q;
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    case (act_reg)
                        ACT_FIND:
                        begin
                            res_next = '{root: KEY_W'(found_root), member: '0,
                                         merged: 1'b0, last: 1'b1};
                            state_next = S_EMIT;
                        end
                        ACT_UNITE:
                        begin
                            if (!phase_reg)
                            begin
                                big_next   = found_root;
                                cur_next   = b_reg;
                                rd_addr    = b_reg;
                                steps_next = '0;
                                phase_next = 1'b1;
                            end
                            else if (found_root == big_reg)
                            begin
                                res_next = '{root: KEY_W'(big_reg), member: '0,
                                             merged: 1'b0, last: 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                small_next = found_root;
                                rd_addr    = big_reg;
                                state_next = S_UBIG;
                            end
                        end
                        default:
                        begin
                            root_next  = found_root;
                            cur_next   = found_root;
                            rd_addr    = found_root;
                            cnt_next   = '0;
                            state_next = S_LIST;
                        end
                    endcase
                end
            end
            S_UBIG:
            begin
                sizb_next  = siz_q;
                tailb_next = tail_q;
                rd_addr    = small_reg;
                state_next = S_USMALL;
            end
            S_USMALL:
            begin
                nxt_we    = 1'b1;
                nxt_addr  = tail_big;
                nxt_data  = new_small;
                tail_we   = 1'b1;
                tail_addr = new_big;
                tail_data = tail_small;
                par_we    = 1'b1;
                par_addr  = new_small;
                par_data  = new_big;
                siz_we    = 1'b1;
                siz_addr  = new_big;
                siz_data  = size_sum;
                res_next  = '{root: KEY_W'(new_big), member: '0, merged: 1'b1,
                              last: 1'b1};
                state_next = S_EMIT;
            end
            S_LIST:
            begin
                res = '{root: KEY_W'(root_reg), member: KEY_W'(cur_reg),
                        merged: 1'b0, last: list_end};
                if (slot_free)
                begin
                    res_push = 1'b1;
                    if (list_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = nxt_q;
                        rd_addr  = nxt_q;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cur_reg   <= '0;
            phase_reg <= 1'b0;
            steps_reg <= '0;
            cnt_reg   <= '0;
            act_reg   <= ACT_FIND;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            cnt_reg   <= cnt_next;
            act_reg   <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        root_reg  <= root_next;
        sizb_reg  <= sizb_next;
        tailb_reg <= tailb_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

// File: sv/union_find_with_member_lists.sv
// top level: union-find with union by size and per-set member lists
// depends on ufml_pkg, ufml_in_if, ufml_out_if, ufml_table, ufml_ctrl
//
//  channel | dir | word                                  | handshake
//  req     | in  | action, first_key, second_key         | valid/ready
//  rsp     | out | root, member, merged, last            | valid/ready
//
// after reset the tables are swept over every element; req.ready stays low meanwhile
// one request at a time; the shared root walker follows parent links up to the root
// find: the request is taken, one walk, then the result word is emitted
// unite: two walks, then S_UBIG, S_USMALL (merge writes) and S_EMIT; two walks and S_EMIT when roots match
// list: one walk, then one member word per cycle while rsp is not stalled
// a one-word output register lets the next request in while a word waits on rsp
`default_nettype none

module union_find_with_member_lists import ufml_pkg::*; #(
    parameter int unsigned ELEMENT_COUNT = DEF_ELEMENT_COUNT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ufml_in_if.sink     req,
    ufml_out_if.source  rsp
);

    localparam int unsigned IDX_W  = $clog2(ELEMENT_COUNT);
    localparam int unsigned SIZE_W = $clog2(ELEMENT_COUNT + 1);

    logic [IDX_W-1:0]  rd_addr;
    logic              par_we, siz_we, tail_we, nxt_we;
    logic [IDX_W-1:0]  par_addr, siz_addr, tail_addr, nxt_addr;
    logic [IDX_W-1:0]  par_data, tail_data, nxt_data;
    logic [SIZE_W-1:0] siz_data;
    logic [IDX_W-1:0]  par_q, tail_q, nxt_q;
    logic [SIZE_W-1:0] siz_q;
    logic              slot_free;
    logic              res_push;
    ufml_res_t         res;

    logic              out_valid_reg;
    ufml_res_t         out_word_reg;

    ufml_table #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_table (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .par_we    (par_we),
        .par_addr  (par_addr),
        .par_data  (par_data),
        .siz_we    (siz_we),
        .siz_addr  (siz_addr),
        .siz_data  (siz_data),
        .tail_we   (tail_we),
        .tail_addr (tail_addr),
        .tail_data (tail_data),
        .nxt_we    (nxt_we),
        .nxt_addr  (nxt_addr),
        .nxt_data  (nxt_data),
        .par_q     (par_q),
        .siz_q     (siz_q),
        .tail_q    (tail_q),
        .nxt_q     (nxt_q)
    );

    ufml_ctrl #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_first  (req.first_key),
        .req_second (req.second_key),
        .req_ready  (req.ready),
        .rd_addr    (rd_addr),
        .par_we     (par_we),
        .par_addr   (par_addr),
        .par_data   (par_data),
        .siz_we     (siz_we),
        .siz_addr   (siz_addr),
        .siz_data   (siz_data),
        .tail_we    (tail_we),
        .tail_addr  (tail_addr),
        .tail_data  (tail_data),
        .nxt_we     (nxt_we),
        .nxt_addr   (nxt_addr),
        .nxt_data   (nxt_data),
        .par_q      (par_q),
        .siz_q      (siz_q),
        .tail_q     (tail_q),
        .nxt_q      (nxt_q),
        .slot_free  (slot_free),
        .res_push   (res_push),
        .res        (res)
    );

    assign slot_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_push)
        begin
            out_word_reg <= res;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.root   = out_word_reg.root;
    assign rsp.member = out_word_reg.member;
    assign rsp.merged = out_word_reg.merged;
    assign rsp.last   = out_word_reg.last;

endmodule

`default_nettype wire

// File: sv/ufml_checker.sv
// port-level checks for union_find_with_member_lists, attached by bind
// depends on ufml_pkg
`default_nettype none

module ufml_checker import ufml_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic [ACT_W-1:0] req_action,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [KEY_W-1:0] rsp_root,
    input wire logic [KEY_W-1:0] rsp_member,
    input wire logic             rsp_merged,
    input wire logic             rsp_last
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root)
            && $stable(rsp_member) && $stable(rsp_merged) && $stable(rsp_last))
        else $error("stalled result word changed");

    // a real request drops req_ready in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_UNITE || req_action == ACT_FIND
            || req_action == ACT_LIST) |=> !req_ready)
        else $error("ready right after a request");

    // a merge is a single closing word without a member
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_merged |-> rsp_last && rsp_member == '0)
        else $error("merged word malformed");

    // only list words can be non-final, and they never merge
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !rsp_merged)
        else $error("non-final word marked merged");

endmodule

bind union_find_with_member_lists ufml_checker u_ufml_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_action (req.action),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_root   (rsp.root),
    .rsp_member (rsp.member),
    .rsp_merged (rsp.merged),
    .rsp_last   (rsp.last)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// testbench for union_find_with_member_lists: directed table, then random requests
// depends on ufml_pkg, ufml_in_if, ufml_out_if and the block itself

module tb_top;
    import ufml_pkg::*;

    localparam int unsigned ELEMS        = DEF_ELEMENT_COUNT;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned LIMIT        = 2000000;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] k1;
        logic [KEY_W-1:0] k2;
        bit               pinned;
        ufml_res_t        word;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ufml_in_if  req_ch ();
    ufml_out_if rsp_ch ();

    union_find_with_member_lists #(.ELEMENT_COUNT(ELEMS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    int set_parent [ELEMS];
    int set_members[ELEMS];
    int tail_of    [ELEMS];
    int next_of    [ELEMS];

    ufml_res_t pending_words[$];
    ufml_res_t step_words[$];
    plan_row_t plan[$];

    logic      pinned_en;
    ufml_res_t pinned_word;
    ufml_res_t got_word;
    ufml_res_t exp_word;

    int  errors;
    int  cycle_count;
    int  burst_left;
    bit  hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic ufml_res_t make_word(int root, int member, bit merged, bit last);
        ufml_res_t w;
        w.root   = root[KEY_W-1:0];
        w.member = member[KEY_W-1:0];
        w.merged = merged;
        w.last   = last;
        return w;
    endfunction

    function automatic int find_root(int k);
        int p;
        for (int steps = 0; steps < ELEMS; steps++)
        begin
            p = set_parent[k];
            if (p == k || p >= ELEMS)
                break;
            k = p;
        end
        return k;
    endfunction

    // updates the tables and leaves the words this request causes in step_words
    function automatic void apply_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k1,
                                          logic [KEY_W-1:0] k2);
        int  a;
        int  b;
        int  keep_root;
        int  absorbed;
        int  swap;
        int  cur;
        int  nx;
        int  n;
        bit  done;
        a = int'(k1);
        b = int'(k2);
        step_words.delete();
        case (act)
            ACT_UNITE:
            begin
                if (a >= ELEMS || b >= ELEMS)
                    step_words.push_back(make_word(a, 0, 1'b0, 1'b1));
                else
                begin
                    keep_root = find_root(a);
                    absorbed  = find_root(b);
                    if (keep_root == absorbed)
                        step_words.push_back(make_word(keep_root, 0, 1'b0, 1'b1));
                    else
                    begin
                        if (set_members[keep_root] < set_members[absorbed])
                        begin
                            swap      = keep_root;
                            keep_root = absorbed;
                            absorbed  = swap;
                        end
                        next_of[tail_of[keep_root]] = absorbed;
                        tail_of[keep_root]          = tail_of[absorbed];
                        set_parent[absorbed]        = keep_root;
                        set_members[keep_root]      = set_members[keep_root]
                                                      + set_members[absorbed];
                        step_words.push_back(make_word(keep_root, 0, 1'b1, 1'b1));
                    end
                end
            end
            ACT_FIND:
            begin
                step_words.push_back(make_word((a < ELEMS) ? find_root(a) : a, 0, 1'b0, 1'b1));
            end
            ACT_LIST:
            begin
                if (a >= ELEMS)
                    step_words.push_back(make_word(a, a, 1'b0, 1'b1));
                else
                begin
                    cur  = find_root(a);
                    n    = 0;
                    done = 1'b0;
                    swap = cur;
                    while (!done)
                    begin
                        nx   = next_of[cur];
                        done = (nx == cur) || (nx >= ELEMS) || (n + 1 >= MAX_RESULTS);
                        step_words.push_back(make_word(swap, cur, 1'b0, done));
                        n++;
                        cur = nx;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (errors < 40)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // one monitor for both channels: check the result word, then predict the request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_word = make_word(int'(rsp_ch.root), int'(rsp_ch.member),
                                     rsp_ch.merged, rsp_ch.last);
                if (pending_words.size() == 0)
                    report_error($sformatf("unexpected word root=%0d member=%0d merged=%0b last=%0b",
                                           got_word.root, got_word.member,
                                           got_word.merged, got_word.last));
                else
                begin
                    exp_word = pending_words.pop_front();
                    if (got_word.root !== exp_word.root || got_word.member !== exp_word.member ||
                        got_word.merged !== exp_word.merged || got_word.last !== exp_word.last)
                        report_error($sformatf({"word mismatch got %0d/%0d/%0b/%0b",
                                                " exp %0d/%0d/%0b/%0b"},
                                               got_word.root, got_word.member,
                                               got_word.merged, got_word.last,
                                               exp_word.root, exp_word.member,
                                               exp_word.merged, exp_word.last));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(req_ch.action, req_ch.first_key, req_ch.second_key);
                if (pinned_en && step_words.size() == 1)
                    pending_words.push_back(pinned_word);
                else
                    foreach (step_words[i])
                        pending_words.push_back(step_words[i]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        hold_left    = 0;
        mode         = 0;
        mode_left    = 0;
        phase        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k1,
                             input logic [KEY_W-1:0] k2, input bit pinned,
                             input ufml_res_t word);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.first_key  <= k1;
        req_ch.second_key <= k2;
        pinned_en         <= pinned;
        pinned_word       <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_row(logic [ACT_W-1:0] act, int k1, int k2, bit pinned,
                                    int root, int member, bit merged, bit last);
        plan_row_t row;
        row.act    = act;
        row.k1     = k1[KEY_W-1:0];
        row.k2     = k2[KEY_W-1:0];
        row.pinned = pinned;
        row.word   = make_word(root, member, merged, last);
        plan.push_back(row);
    endfunction

    initial
    begin : stimulus
        int               pick;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] k1;
        logic [KEY_W-1:0] k2;
        errors            = 0;
        cycle_count       = 0;
        burst_left        = 0;
        hold_request      = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_UNITE;
        req_ch.first_key  = '0;
        req_ch.second_key = '0;
        pinned_en         = 1'b0;
        pinned_word       = '0;
        for (int i = 0; i < ELEMS; i++)
        begin
            set_parent[i]  = i;
            set_members[i] = 1;
            tail_of[i]     = i;
            next_of[i]     = i;
        end

        // singletons after reset, key extremes, equal-size tie, unused action
        add_row(ACT_FIND,   0,  0,  1, 0,  0,  0, 1);
        add_row(ACT_FIND,   63, 0,  1, 63, 0,  0, 1);
        add_row(ACT_LIST,   63, 63, 1, 63, 63, 0, 1);
        add_row(ACT_LIST,   0,  63, 1, 0,  0,  0, 1);
        add_row(ACT_UNITE,  0,  0,  1, 0,  0,  0, 1);
        add_row(ACT_UNITE,  0,  63, 1, 0,  0,  1, 1);
        add_row(ACT_UNITE,  63, 0,  1, 0,  0,  0, 1);
        add_row(ACT_FIND,   63, 63, 1, 0,  0,  0, 1);
        add_row(ACT_LIST,   63, 0,  0, 0,  0,  0, 0);
        add_row(ACT_UNITE,  1,  2,  1, 1,  0,  1, 1);
        add_row(ACT_UNITE,  2,  0,  1, 1,  0,  1, 1);
        add_row(ACT_LIST,   0,  0,  0, 0,  0,  0, 0);
        add_row(ACT_UNITE,  5,  1,  1, 1,  0,  1, 1);
        add_row(ACT_FIND,   5,  0,  1, 1,  0,  0, 1);
        add_row(ACT_UNUSED, 7,  9,  0, 0,  0,  0, 0);
        add_row(ACT_UNUSED, 63, 63, 0, 0,  0,  0, 0);
        add_row(ACT_UNITE,  42, 21, 1, 42, 0,  1, 1);
        add_row(ACT_UNITE,  21, 42, 1, 42, 0,  0, 1);
        add_row(ACT_LIST,   42, 0,  0, 0,  0,  0, 0);
        add_row(ACT_FIND,   21, 63, 1, 42, 0,  0, 1);
        add_row(ACT_LIST,   5,  0,  0, 0,  0,  0, 0);
        add_row(ACT_FIND,   62, 0,  1, 62, 0,  0, 1);
        add_row(ACT_UNITE,  62, 42, 0, 0,  0,  0, 0);
        add_row(ACT_UNITE,  21, 5,  0, 0,  0,  0, 0);
        add_row(ACT_LIST,   62, 0,  0, 0,  0,  0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_word(plan[i].act, plan[i].k1, plan[i].k2, plan[i].pinned, plan[i].word);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                hold_request = 1'b1;
            if (i == 250)
                drain_results();
            pick = $urandom_range(0, 99);
            k1   = KEY_W'($urandom_range(0, 63));
            k2   = KEY_W'($urandom_range(0, 63));
            if (pick < 25)
                act = ACT_UNITE;
            else if (pick < 55)
                act = ACT_FIND;
            else if (pick < 93)
                act = ACT_LIST;
            else
                act = ACT_UNUSED;
            send_word(act, k1, k2, 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: union_find_with_member_lists.f
sv/ufml_pkg.sv
sv/ufml_in_if.sv
sv/ufml_out_if.sv
sv/ufml_table.sv
sv/ufml_ctrl.sv
sv/union_find_with_member_lists.sv
sv/ufml_checker.sv
test/tb_top.sv
